// File: src/dnsd_pkg.sv
`default_nettype none
package dnsd_pkg;

    // defaults for the top level parameters
    localparam int DEF_PACKET_BYTES = 512;
    localparam int DEF_MAX_NAME     = 255;
    localparam int DEF_MAX_HOPS     = 16;

    // positions and pointer targets share one width (14-bit pointers)
    localparam int POS_W = 14;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 88;

    localparam logic [7:0] PTR_TAG    = 8'hC0;
    localparam logic [7:0] LABEL_MASK = 8'h3F;
    localparam logic [7:0] DOT_CHAR   = 8'h2E;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_PTR_RANGE = 3'd1;
    localparam logic [2:0] ST_HOPS      = 3'd2;
    localparam logic [2:0] ST_TOO_LONG  = 3'd3;
    localparam logic [2:0] ST_OVERRUN   = 3'd4;

endpackage
`default_nettype wire

// File: src/dns_name_decompressor.sv
`default_nettype none
// load beat: written into the packet store, no result
// extract beat: each packet byte read passes a store read issue state, then a use state; a dot
//   and the end of each label pass a state of their own, and the final chunk goes out last; the single
//   read port of the packet store sets this pace, and output stalls add to it
// a new beat is accepted only between extractions; a pending result may still wait
// reset clears control state and the output valid flag; the packet store is not cleared
module dns_name_decompressor
    import dnsd_pkg::*;
#(
    parameter int PACKET_BYTES = DEF_PACKET_BYTES,
    parameter int MAX_NAME     = DEF_MAX_NAME,
    parameter int MAX_HOPS     = DEF_MAX_HOPS
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // byte_address[8:0], byte_value[16:9], start_offset[25:17], packet_length[35:26]
    input  wire [IN_TDATA_W-1:0]   s_axis_tdata,
    // op[0]
    input  wire                    s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // name_chunk[63:0], chunk_count[67:64], next_offset[77:68], status[80:78]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // last_chunk
    output logic                   m_axis_tlast
);

    localparam int AW = $clog2(PACKET_BYTES);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_LEN_RD = 8'b0000_0010,   // issue read of a length byte
        S_LEN    = 8'b0000_0100,   // decode length byte
        S_PLO_RD = 8'b0000_1000,   // issue read of pointer low byte
        S_PLO    = 8'b0001_0000,   // follow pointer
        S_DOT    = 8'b0010_0000,   // push separator
        S_LAB_RD = 8'b0100_0000,   // issue read of a label byte
        S_LAB    = 8'b1000_0000    // push label byte
    } t_state;

    // packet store, one synchronous read port
    logic [7:0] r_mem [PACKET_BYTES];
    logic [7:0] r_mem_q;

    t_state            r_state, n_state;
    logic              r_fin, n_fin;          // final chunk pending
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_plen, n_plen;
    logic [POS_W-1:0]  r_resume, n_resume;
    logic [4:0]        r_hops, n_hops;
    logic [7:0]        r_name_len, n_name_len;
    logic [7:0]        r_lab_left, n_lab_left;
    logic [5:0]        r_ptr_hi, n_ptr_hi;
    logic              r_had_label, n_had_label;
    logic [63:0]       r_chunk, n_chunk;
    logic [3:0]        r_fill, n_fill;
    logic [2:0]        r_status, n_status;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_last;

    logic              in_beat;
    logic              out_free;
    logic              emit;
    logic              emit_last;
    logic [9:0]        emit_next;
    logic [2:0]        emit_status;
    logic [63:0]       emit_chunk;
    logic [3:0]        emit_count;
    logic              rd_en;
    logic              wr_en;
    logic [POS_W-1:0]  wr_pos;
    logic [POS_W-1:0]  start_pos;
    logic [POS_W-1:0]  plen_in;
    logic [POS_W-1:0]  ptr;
    logic [POS_W-1:0]  next_pos;
    logic [7:0]        push_ch;

    assign s_axis_tready = (r_state == S_IDLE) && !r_fin;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign wr_pos    = POS_W'(s_axis_tdata[8:0]);
    assign start_pos = POS_W'(s_axis_tdata[25:17]);
    assign plen_in   = POS_W'(s_axis_tdata[35:26]);
    assign wr_en     = in_beat && (s_axis_tuser == OP_LOAD)
                       && (wr_pos < POS_W'(PACKET_BYTES));
    assign ptr       = POS_W'({r_ptr_hi, r_mem_q});
    assign next_pos  = (r_resume != '0) ? r_resume : r_pos;
    assign push_ch   = (r_state == S_DOT) ? DOT_CHAR : r_mem_q;

    always_comb begin
        n_state     = r_state;
        n_fin       = r_fin;
        n_pos       = r_pos;
        n_plen      = r_plen;
        n_resume    = r_resume;
        n_hops      = r_hops;
        n_name_len  = r_name_len;
        n_lab_left  = r_lab_left;
        n_ptr_hi    = r_ptr_hi;
        n_had_label = r_had_label;
        n_chunk     = r_chunk;
        n_fill      = r_fill;
        n_status    = r_status;
        emit        = 1'b0;
        emit_last   = 1'b0;
        emit_next   = '0;
        emit_status = ST_OK;
        emit_chunk  = r_chunk;
        emit_count  = r_fill;
        rd_en       = 1'b0;

        if (r_fin) begin
            // final chunk, carries offset and status
            if (out_free) begin
                emit        = 1'b1;
                emit_last   = 1'b1;
                emit_status = r_status;
                emit_next   = (r_status == ST_OK) ? next_pos[9:0] : 10'd0;
                n_fin       = 1'b0;
                n_state     = S_IDLE;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_beat && (s_axis_tuser == OP_EXTRACT)) begin
                        n_plen      = (plen_in > POS_W'(PACKET_BYTES))
                                      ? POS_W'(PACKET_BYTES) : plen_in;
                        n_pos       = start_pos;
                        n_resume    = '0;
                        n_hops      = '0;
                        n_name_len  = '0;
                        n_had_label = 1'b0;
                        n_chunk     = '0;
                        n_fill      = '0;
                        n_status    = ST_OK;
                        n_state     = S_LEN_RD;
                    end
                end
                S_LEN_RD: begin
                    if (r_pos >= r_plen) begin
                        n_status = ST_OVERRUN;
                        n_fin    = 1'b1;
                    end else begin
                        rd_en   = 1'b1;
                        n_pos   = r_pos + 1'b1;
                        n_state = S_LEN;
                    end
                end
                S_LEN: begin
                    if ((r_mem_q & PTR_TAG) == PTR_TAG) begin
                        n_ptr_hi = 6'(r_mem_q & LABEL_MASK);
                        n_state  = S_PLO_RD;
                    end else if (r_mem_q == 8'd0) begin
                        n_status = ST_OK;
                        n_fin    = 1'b1;
                    end else begin
                        n_lab_left  = r_mem_q;
                        n_had_label = 1'b1;
                        n_state     = r_had_label ? S_DOT : S_LAB_RD;
                    end
                end
                S_PLO_RD: begin
                    if (r_pos >= r_plen) begin
                        n_status = ST_OVERRUN;
                        n_fin    = 1'b1;
                    end else begin
                        rd_en   = 1'b1;
                        n_pos   = r_pos + 1'b1;
                        n_state = S_PLO;
                    end
                end
                S_PLO: begin
                    if (ptr >= r_plen) begin
                        n_status = ST_PTR_RANGE;
                        n_fin    = 1'b1;
                    end else if (r_hops >= 5'(MAX_HOPS)) begin
                        n_status = ST_HOPS;
                        n_fin    = 1'b1;
                    end else begin
                        n_hops = r_hops + 1'b1;
                        if (r_resume == '0) begin
                            n_resume = r_pos;
                        end
                        n_pos   = ptr;
                        n_state = S_LEN_RD;
                    end
                end
                S_LAB_RD: begin
                    if (r_lab_left == 8'd0) begin
                        n_state = S_LEN_RD;
                    end else if (r_pos >= r_plen) begin
                        n_status = ST_OVERRUN;
                        n_fin    = 1'b1;
                    end else begin
                        rd_en   = 1'b1;
                        n_state = S_LAB;
                    end
                end
                S_DOT, S_LAB: begin
                    if (r_name_len >= 8'(MAX_NAME)) begin
                        n_status = ST_TOO_LONG;
                        n_fin    = 1'b1;
                    end else if (r_fill[3]) begin
                        // full chunk goes out only once a ninth character shows up
                        if (out_free) begin
                            emit       = 1'b1;
                            n_chunk    = {56'd0, push_ch};
                            n_fill     = 4'd1;
                            n_name_len = r_name_len + 1'b1;
                            if (r_state == S_LAB) begin
                                n_pos      = r_pos + 1'b1;
                                n_lab_left = r_lab_left - 1'b1;
                            end
                            n_state = S_LAB_RD;
                        end
                    end else begin
                        n_chunk[8*r_fill[2:0] +: 8] = push_ch;
                        n_fill     = r_fill + 1'b1;
                        n_name_len = r_name_len + 1'b1;
                        if (r_state == S_LAB) begin
                            n_pos      = r_pos + 1'b1;
                            n_lab_left = r_lab_left - 1'b1;
                        end
                        n_state = S_LAB_RD;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    // packet store: loads write, the walk reads
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_pos[AW-1:0]] <= s_axis_tdata[16:9];
        end
        if (rd_en) begin
            r_mem_q <= r_mem[r_pos[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fin       <= 1'b0;
            r_pos       <= '0;
            r_resume    <= '0;
            r_hops      <= '0;
            r_name_len  <= '0;
            r_fill      <= '0;
            r_had_label <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fin       <= n_fin;
            r_pos       <= n_pos;
            r_resume    <= n_resume;
            r_hops      <= n_hops;
            r_name_len  <= n_name_len;
            r_fill      <= n_fill;
            r_had_label <= n_had_label;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_plen     <= n_plen;
        r_lab_left <= n_lab_left;
        r_ptr_hi   <= n_ptr_hi;
        r_chunk    <= n_chunk;
        r_status   <= n_status;
        if (emit) begin
            r_out_data <= {7'd0, emit_status, emit_next, emit_count, emit_chunk};
            r_out_last <= emit_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import dnsd_pkg::*;

    localparam int STORE_BYTES  = DEF_PACKET_BYTES;
    localparam int NAME_LIMIT   = DEF_MAX_NAME;
    localparam int HOP_LIMIT    = DEF_MAX_HOPS;
    localparam int ITEM_TARGET  = 360;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int GAP_PERCENT  = 37;
    localparam int PRINT_LIMIT  = 50;

    // one result beat: up to 8 name characters plus the closing fields
    typedef struct {
        logic [63:0] chars;
        logic [3:0]  count;
        logic        last;
        logic [9:0]  next_off;
        logic [2:0]  status;
    } t_chunk;

    // mirror of the packet store plus the name walk, and the queue of chunks still owed
    class name_scoreboard;
        logic [7:0] store [STORE_BYTES];
        bit         written [STORE_BYTES];
        t_chunk     expected_chunks[$];
        t_chunk     walk_chunks[$];
        logic [63:0] acc;
        int         fill;
        int         name_len;
        int         errors;
        bit         blind_read;

        function new();
            errors = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT) $display("mismatch: %s", msg);
            errors++;
        endtask

        // flags any read of an entry that was never loaded
        function logic [7:0] fetch(int addr);
            if (!written[addr]) blind_read = 1'b1;
            return store[addr];
        endfunction

        function void emit(logic last, int next_off, logic [2:0] status);
            t_chunk c;
            c.chars    = acc;
            c.count    = 4'(fill);
            c.last     = last;
            c.next_off = 10'(next_off);
            c.status   = status;
            walk_chunks.push_back(c);
            acc  = '0;
            fill = 0;
        endfunction

        // a full chunk goes out only once a ninth character shows up
        function bit add_char(logic [7:0] ch);
            if (name_len >= NAME_LIMIT) return 1'b0;
            if (fill >= 8) emit(1'b0, 0, ST_OK);
            acc[8*fill +: 8] = ch;
            fill++;
            name_len++;
            return 1'b1;
        endfunction

        // walks labels and pointers from start, leaves the chunks in walk_chunks
        function void decode_name(logic [8:0] start, logic [9:0] plen_in);
            int         plen, pos, resume, hops, target;
            logic [7:0] len_byte;
            logic [2:0] status;
            bit         had_label, done;
            walk_chunks.delete();
            acc        = '0;
            fill       = 0;
            name_len   = 0;
            blind_read = 1'b0;
            plen       = (int'(plen_in) > STORE_BYTES) ? STORE_BYTES : int'(plen_in);
            pos        = int'(start);
            resume     = 0;
            hops       = 0;
            had_label  = 1'b0;
            done       = 1'b0;
            status     = ST_OK;
            while (!done) begin
                if (pos >= plen) begin
                    status = ST_OVERRUN;
                    break;
                end
                len_byte = fetch(pos);
                pos++;
                if ((len_byte & PTR_TAG) == PTR_TAG) begin
                    if (pos >= plen) begin
                        status = ST_OVERRUN;
                        break;
                    end
                    target = int'({len_byte & LABEL_MASK, fetch(pos)});
                    pos++;
                    if (target >= plen) begin
                        status = ST_PTR_RANGE;
                        break;
                    end
                    if (hops >= HOP_LIMIT) begin
                        status = ST_HOPS;
                        break;
                    end
                    hops++;
                    if (resume == 0) resume = pos;
                    pos = target;
                end else if (len_byte == 8'h00) begin
                    done = 1'b1;
                end else begin
                    if (had_label && !add_char(DOT_CHAR)) begin
                        status = ST_TOO_LONG;
                        break;
                    end
                    for (int i = 0; i < int'(len_byte); i++) begin
                        if (pos >= plen) begin
                            status = ST_OVERRUN;
                            done   = 1'b1;
                            break;
                        end
                        if (!add_char(fetch(pos))) begin
                            status = ST_TOO_LONG;
                            done   = 1'b1;
                            break;
                        end
                        pos++;
                    end
                    had_label = 1'b1;
                end
            end
            emit(1'b1, (status == ST_OK) ? ((resume != 0) ? resume : pos) : 0, status);
        endfunction

        function bit walk_is_safe(logic [8:0] start, logic [9:0] plen);
            decode_name(start, plen);
            return !blind_read;
        endfunction

        function int written_prefix();
            int n;
            n = 0;
            while (n < STORE_BYTES && written[n]) n++;
            return n;
        endfunction

        function void note_beat(logic op, logic [8:0] addr, logic [7:0] value,
                                logic [8:0] start, logic [9:0] plen);
            if (op == OP_LOAD) begin
                store[addr]   = value;
                written[addr] = 1'b1;
            end else begin
                decode_name(start, plen);
                foreach (walk_chunks[i]) expected_chunks.push_back(walk_chunks[i]);
            end
        endfunction

        task compare(string field, logic [63:0] got, logic [63:0] want);
            if (got !== want) report($sformatf("%s got %0h expected %0h", field, got, want));
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] data, logic last);
            t_chunk want;
            if (expected_chunks.size() == 0) begin
                report("result beat with no chunk expected");
                return;
            end
            want = expected_chunks.pop_front();
            compare("name_chunk", data[63:0], want.chars);
            compare("chunk_count", 64'(data[67:64]), 64'(want.count));
            compare("last_chunk", 64'(last), 64'(want.last));
            compare("next_offset", 64'(data[77:68]), 64'(want.next_off));
            compare("status", 64'(data[80:78]), 64'(want.status));
        endtask

        function int pending();
            return expected_chunks.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    wire                    s_axis_tready;
    // byte_address[8:0], byte_value[16:9], start_offset[25:17], packet_length[35:26]
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // op[0]
    logic                   s_axis_tuser;
    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // name_chunk[63:0], chunk_count[67:64], next_offset[77:68], status[80:78]
    wire [OUT_TDATA_W-1:0]  m_axis_tdata;
    // last_chunk
    wire                    m_axis_tlast;

    name_scoreboard names_sb;
    int  items_sent  = 0;
    int  cycle_count = 0;
    int  cursor;
    int  name_starts[$];
    bit  no_gaps = 1'b0;

    dns_name_decompressor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic bit take_gap();
        return !no_gaps && ($urandom_range(99) < GAP_PERCENT);
    endfunction

    // result side stalls at random, except inside the quiet stretch
    always @(negedge i_clk) begin
        m_axis_tready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
    end

    // every accepted result beat is checked against the oldest owed chunk
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            names_sb.check_result(m_axis_tdata, m_axis_tlast);
        end
    end

    // presents one beat at a falling edge and holds it until a rising edge takes it
    task automatic send_beat(logic op, logic [8:0] addr, logic [7:0] value,
                             logic [8:0] start, logic [9:0] plen);
        while (take_gap()) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = '0;
        s_axis_tdata[8:0]   = addr;
        s_axis_tdata[16:9]  = value;
        s_axis_tdata[25:17] = start;
        s_axis_tdata[35:26] = plen;
        do @(posedge i_clk); while (!s_axis_tready);
        names_sb.note_beat(op, addr, value, start, plen);
        items_sent++;
        // one long stretch with no stalls on either side
        no_gaps = (items_sent >= 180) && (items_sent < 260);
        @(negedge i_clk);
    endtask

    // unused fields of a beat still carry random bits
    task automatic load_byte(int addr, int value);
        send_beat(OP_LOAD, 9'(addr), 8'(value), 9'($urandom_range(511)),
                  10'($urandom_range(1023)));
    endtask

    // never lets the walk touch a store entry that was not loaded: if it
    // would, the packet length is cut back to the loaded prefix
    task automatic extract_name(int start, int plen);
        if (!names_sb.walk_is_safe(9'(start), 10'(plen))) plen = names_sb.written_prefix();
        send_beat(OP_EXTRACT, 9'($urandom_range(511)), 8'($urandom_range(255)),
                  9'(start), 10'(plen));
    endtask

    // compression pointer: tag plus 14-bit target
    task automatic write_pointer(int at, int target);
        load_byte(at, int'(PTR_TAG) | ((target >> 8) & int'(LABEL_MASK)));
        load_byte(at + 1, target & 8'hFF);
    endtask

    // lays down one name at the cursor, then extracts from it or near it
    task automatic build_and_extract();
        int base, pos, len, roll, start, plen;
        bit stopped;
        stopped = 1'b0;
        if (cursor > STORE_BYTES - 64) cursor = $urandom_range(11, 200);
        base = cursor;
        pos  = base;
        if ($urandom_range(99) < 10) begin
            // one label and a pointer back to it: repeats until the name is too long
            len = $urandom_range(15, 40);
            load_byte(pos, len);
            pos++;
            repeat (len) begin
                load_byte(pos, $urandom_range(97, 122));
                pos++;
            end
            write_pointer(pos, base);
            pos += 2;
        end else begin
            repeat ($urandom_range(0, 4)) begin
                if (!stopped) begin
                    if ($urandom_range(14) == 0) begin
                        // reserved label type, taken whole as a long length
                        load_byte(pos, $urandom_range(64, 191));
                        pos++;
                        stopped = 1'b1;
                    end else begin
                        len = $urandom_range(1, 10);
                        load_byte(pos, len);
                        pos++;
                        repeat (len) begin
                            load_byte(pos, $urandom_range(1) ? $urandom_range(97, 122)
                                                             : $urandom_range(255));
                            pos++;
                        end
                    end
                end
            end
            if (!stopped) begin
                roll = $urandom_range(99);
                if (roll < 60) begin
                    load_byte(pos, 0);
                    pos++;
                end else begin
                    if (roll < 85)
                        write_pointer(pos, name_starts[$urandom_range(name_starts.size() - 1)]);
                    else if (roll < 95)
                        write_pointer(pos, $urandom_range(16383));
                    else
                        write_pointer(pos, base);
                    pos += 2;
                end
            end
        end
        name_starts.push_back(base);
        cursor = pos;

        // stray writes, possibly over older names
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 3)) load_byte($urandom_range(511), $urandom_range(255));
        end

        repeat ($urandom_range(1, 2)) begin
            roll = $urandom_range(9);
            if (roll == 0)
                start = $urandom_range(511);
            else if (roll < 4)
                start = name_starts[$urandom_range(name_starts.size() - 1)];
            else
                start = base;
            roll = $urandom_range(99);
            if (roll < 40)
                plen = $urandom_range(pos, STORE_BYTES - 1);
            else if (roll < 70)
                plen = $urandom_range(STORE_BYTES, 1023);
            else if (roll < 90)
                plen = $urandom_range(start, pos);
            else
                plen = $urandom_range(1023);
            extract_name(start, plen);
        end
    endtask

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = OP_LOAD;
        s_axis_tdata  = '0;
        i_rst_n       = 1'b0;
        names_sb      = new();
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed packet: "abc" at 0, pointer to it at 5, self pointer at 7,
        // far pointer at 9, empty name in the last store entry
        load_byte(0, 3);
        load_byte(1, 8'h61);
        load_byte(2, 8'h62);
        load_byte(3, 8'h63);
        load_byte(4, 0);
        write_pointer(5, 0);
        write_pointer(7, 7);
        write_pointer(9, 511);
        load_byte(511, 0);
        extract_name(0, 5);       // plain name ending at the packet end
        extract_name(0, 4);       // terminator falls past the length
        extract_name(5, 1023);    // length saturates, resume after the pointer
        extract_name(7, 9);       // pointer loop runs out of hops
        extract_name(9, 11);      // pointer target beyond the length
        extract_name(9, 10);      // pointer low byte past the length
        extract_name(0, 0);       // start at the length, nothing read
        extract_name(511, 1023);  // empty name, next offset at the store end
        name_starts.push_back(0);
        name_starts.push_back(5);
        cursor = 11;

        while (items_sent < ITEM_TARGET) build_and_extract();
        s_axis_tvalid = 1'b0;
        no_gaps       = 1'b0;

        while (names_sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (names_sb.pending() != 0)
            names_sb.report($sformatf("%0d chunks never arrived", names_sb.pending()));
        if (names_sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
src/dnsd_pkg.sv
src/dns_name_decompressor.sv
dv/testbench.sv
